[design/hsvled_pkg.sv]
package hsvled_pkg;

  // configuration register indexes
  localparam logic [2:0] RegPixelOrder = 3'd0;
  localparam logic [2:0] RegCodePair00 = 3'd1;
  localparam logic [2:0] RegCodePair01 = 3'd2;
  localparam logic [2:0] RegCodePair10 = 3'd3;
  localparam logic [2:0] RegCodePair11 = 3'd4;

  // pixel order codes
  localparam logic [1:0] OrderGrb  = 2'd0;
  localparam logic [1:0] OrderRgb  = 2'd1;
  localparam logic [1:0] OrderRgbw = 2'd2;

  // reset values of the code words
  localparam logic [7:0] CodePair00Rst = 8'd136;
  localparam logic [7:0] CodePair01Rst = 8'd140;
  localparam logic [7:0] CodePair10Rst = 8'd200;
  localparam logic [7:0] CodePair11Rst = 8'd204;

  // index of the last spi byte of a pixel
  localparam logic [3:0] LastByte3Ch = 4'd11;
  localparam logic [3:0] LastByte4Ch = 4'd15;

  localparam int unsigned QueueDepth = 2;

  // one converted pixel, channel bytes in emission order, first in [31:24]
  typedef struct packed {
    logic [31:0] chans;
    logic        rgbw;
    logic        last;
  } pix_word_t;

  // x mod 6 for an 8-bit value via reciprocal multiply (171/1024)
  function automatic logic [2:0] mod6(input logic [7:0] x);
    logic [15:0] p;
    logic [8:0]  q9;
    logic [8:0]  r;
    p  = {8'd0, x} * 16'd171;
    q9 = {3'd0, p[15:10]};
    r  = {1'b0, x} - q9 * 9'd6;
    return r[2:0];
  endfunction

endpackage

[design/hsvled_front.sv]
module hsvled_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [15:0]            hue_i,
  input  logic [7:0]             saturation_i,
  input  logic [7:0]             brightness_i,
  input  logic                   last_pixel_i,
  input  logic [1:0]             pixel_order_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hsvled_pkg::pix_word_t  out_word_o
);

  // stage 1: base product and slope product
  logic        v1_q, v1_d;
  logic [7:0]  val1_q;
  logic        grey1_q;
  logic [2:0]  sec1_q;
  logic [15:0] m1_q;
  logic [15:0] prod1_q;
  logic        last1_q;

  // stage 2: base level and raw slope
  logic        v2_q, v2_d;
  logic [7:0]  val2_q;
  logic        grey2_q;
  logic [2:0]  sec2_q;
  logic [7:0]  base2_q;
  logic [23:0] slope2_q;
  logic        last2_q;

  logic        rdy1, rdy2;
  logic [2:0]  sec_in;
  logic [8:0]  ramp;
  logic [16:0] prod_full;
  logic [16:0] tmp_a, tmp_b;
  logic [15:0] slope_mul;
  logic [24:0] slope_sum;
  logic [7:0]  slope_b, col_v, col_s, col_b, white, red, green, blue;
  logic        rgbw;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign sec_in    = hsvled_pkg::mod6(hue_i[15:8]);
  assign ramp      = sec_in[0] ? {1'b0, hue_i[7:0]} : (9'd256 - {1'b0, hue_i[7:0]});
  assign prod_full = {9'd0, saturation_i} * {8'd0, ramp};

  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      val1_q  <= brightness_i;
      grey1_q <= (saturation_i == 8'd0);
      sec1_q  <= sec_in;
      m1_q    <= {8'd0, brightness_i} * {8'd0, 8'd255 - saturation_i};
      prod1_q <= prod_full[15:0];
      last1_q <= last_pixel_i;
    end
  end

  assign tmp_a     = {1'b0, m1_q} + 17'd1;
  assign tmp_b     = tmp_a + (tmp_a >> 8);
  assign slope_mul = 16'hff00 - prod1_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      val2_q   <= val1_q;
      grey2_q  <= grey1_q;
      sec2_q   <= sec1_q;
      base2_q  <= tmp_b[15:8];
      slope2_q <= {16'd0, val1_q} * {8'd0, slope_mul};
      last2_q  <= last1_q;
    end
  end

  // stage 2 output: slope rounding, white extraction, grey, sextant and order mux
  assign rgbw      = (pixel_order_i == hsvled_pkg::OrderRgbw);
  assign slope_sum = {1'b0, slope2_q} + {9'd0, slope2_q[23:8]} + {17'd0, val2_q};
  assign slope_b   = slope_sum[23:16];

  always_comb begin
    col_v = val2_q;
    col_s = slope_b;
    col_b = base2_q;
    white = 8'd0;
    if (rgbw) begin
      white = base2_q;
      col_v = val2_q - base2_q;
      col_s = slope_b - base2_q;
    end
    case (sec2_q)
      3'd0:    begin red = col_v; green = col_s; blue = col_b; end
      3'd1:    begin red = col_s; green = col_v; blue = col_b; end
      3'd2:    begin red = col_b; green = col_v; blue = col_s; end
      3'd3:    begin red = col_b; green = col_s; blue = col_v; end
      3'd4:    begin red = col_s; green = col_b; blue = col_v; end
      default: begin red = col_v; green = col_b; blue = col_s; end
    endcase
    if (grey2_q) begin
      if (rgbw) begin
        white = val2_q;
        red   = 8'd0;
      end else begin
        red   = val2_q;
      end
      green = red;
      blue  = red;
    end
  end

  assign out_valid_o     = v2_q;
  assign out_word_o.chans = (pixel_order_i == hsvled_pkg::OrderGrb) ?
                            {green, red, blue, white} : {red, green, blue, white};
  assign out_word_o.rgbw  = rgbw;
  assign out_word_o.last  = last2_q;

endmodule

[design/hsvled_queue.sv]
module hsvled_queue #(
  parameter int unsigned Depth = hsvled_pkg::QueueDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  hsvled_pkg::pix_word_t           wdata_i,
  input  logic                            pop_i,
  output hsvled_pkg::pix_word_t           rdata_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic [$clog2(Depth+1)-1:0]      level_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hsvled_pkg::pix_word_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign level_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[design/hsvled_back.sv]
module hsvled_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   word_valid_i,
  input  hsvled_pkg::pix_word_t  word_i,
  output logic                   word_take_o,
  input  logic [3:0][7:0]        codes_i,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic [7:0]             spi_byte_o,
  output logic                   pixel_end_o,
  output logic                   frame_end_o
);

  logic        act_q;
  logic [31:0] sh_q;
  logic [3:0]  cnt_q;
  logic        rgbw_q, last_q;
  logic        out_v_q;
  logic [7:0]  byte_q;
  logic        pe_q, fe_q;
  logic        adv, last_byte, load;

  assign last_byte   = (cnt_q == (rgbw_q ? hsvled_pkg::LastByte4Ch : hsvled_pkg::LastByte3Ch));
  assign adv         = act_q && (!out_v_q || pop_i);
  assign load        = word_valid_i && (!act_q || (adv && last_byte));
  assign word_take_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
      if (load) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (adv) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_byte) begin
          act_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= codes_i[sh_q[31:30]];
      pe_q   <= last_byte;
      fe_q   <= last_byte && last_q;
    end
    if (load) begin
      sh_q   <= word_i.chans;
      rgbw_q <= word_i.rgbw;
      last_q <= word_i.last;
    end else if (adv) begin
      sh_q   <= {sh_q[29:0], 2'b00};
    end
  end

  assign empty_o     = !out_v_q;
  assign spi_byte_o  = byte_q;
  assign pixel_end_o = pe_q;
  assign frame_end_o = fe_q;

endmodule

[design/hsv_pixel_to_led_bitstream.sv]
// hsv pixel to led bitstream encoder
// input side is a queue: drive hue_i/saturation_i/brightness_i/last_pixel_i
// and raise push; the word is taken on a clock edge with push high and full low
// output side is a queue: while empty is low the oldest spi byte sits on
// spi_byte_o with pixel_end_o/frame_end_o; raise pop to take it
// each pixel gives 12 spi bytes (grb, rgb) or 16 (rgbw), msb pair first,
// one byte per cycle from the serializer shift register while pop keeps up
// path: the color pipeline stages, the word queue, the serializer shift
// register, then the registered output byte
// the front takes a new pixel every cycle until the queue fills
// when pop stays low the output byte holds, the serializer stops, the queue
// fills and full rises once the two pipeline stages are also occupied
// reset (rst_ni low, async) empties pipeline, queue and serializer and
// restores pixel_order and code words to defaults
// config (cfg_we_i, cfg_index_i, cfg_data_i) may be written only while idle
module hsv_pixel_to_led_bitstream #(
  parameter int unsigned QueueDepth = hsvled_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  brightness_i,
  input  logic        last_pixel_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  spi_byte_o,
  output logic        pixel_end_o,
  output logic        frame_end_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // configuration registers
  logic [1:0]      pixel_order_q;
  logic [3:0][7:0] codes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_order_q <= hsvled_pkg::OrderGrb;
      codes_q[0]    <= hsvled_pkg::CodePair00Rst;
      codes_q[1]    <= hsvled_pkg::CodePair01Rst;
      codes_q[2]    <= hsvled_pkg::CodePair10Rst;
      codes_q[3]    <= hsvled_pkg::CodePair11Rst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hsvled_pkg::RegPixelOrder: pixel_order_q <= cfg_data_i[1:0];
        hsvled_pkg::RegCodePair00: codes_q[0]    <= cfg_data_i;
        hsvled_pkg::RegCodePair01: codes_q[1]    <= cfg_data_i;
        hsvled_pkg::RegCodePair10: codes_q[2]    <= cfg_data_i;
        hsvled_pkg::RegCodePair11: codes_q[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: color conversion pipeline
  logic                  front_rdy;
  logic                  front_v;
  hsvled_pkg::pix_word_t front_word;

  // word queue between front and back
  logic                            q_full, q_empty, q_take;
  hsvled_pkg::pix_word_t           q_word;
  logic [$clog2(QueueDepth+1)-1:0] q_level;

  assign full = !front_rdy;

  hsvled_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (push),
    .in_ready_o    (front_rdy),
    .hue_i         (hue_i),
    .saturation_i  (saturation_i),
    .brightness_i  (brightness_i),
    .last_pixel_i  (last_pixel_i),
    .pixel_order_i (pixel_order_q),
    .out_valid_o   (front_v),
    .out_ready_i   (!q_full),
    .out_word_o    (front_word)
  );

  hsvled_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_v),
    .wdata_i (front_word),
    .pop_i   (q_take),
    .rdata_o (q_word),
    .full_o  (q_full),
    .empty_o (q_empty),
    .level_o (q_level)
  );

  // back: serializer, one spi byte per cycle into the output register while pop keeps up
  hsvled_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (!q_empty),
    .word_i       (q_word),
    .word_take_o  (q_take),
    .codes_i      (codes_q),
    .empty_o      (empty),
    .pop_i        (pop),
    .spi_byte_o   (spi_byte_o),
    .pixel_end_o  (pixel_end_o),
    .frame_end_o  (frame_end_o)
  );

  // queue level stays within its depth
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("word queue level over depth");

  // serializer only takes a word that is there
  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> !q_empty)
    else $error("serializer took from empty queue");

  // frame end only marks a pixel's last byte
  a_frame_on_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> pixel_end_o)
    else $error("frame end without pixel end");

  // a full queue backs up into the front once stage two holds a pixel
  a_stall_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_v && q_full && !q_take) |=> front_v)
    else $error("pixel lost at queue input");

endmodule

[verif/hsv_led_spi_checker.sv]
`timescale 1ns / 100ps

module hsv_led_spi_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [15:0] hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  brightness_i,
  input  logic        last_pixel_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  spi_byte_i,
  input  logic        pixel_end_i,
  input  logic        frame_end_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       pixel_end;
    logic       frame_end;
  } spi_word_t;

  spi_word_t   expected_bytes[$];
  spi_word_t   got_word;
  spi_word_t   want_word;
  logic [1:0]  order_q;
  logic [7:0]  code_q[4];
  int unsigned byte_faults = 0;

  // hsv to rgb(w) with the integer error correction, then two led bits per spi byte
  function automatic void predict_pixel_bytes(input logic [15:0] hue, input logic [7:0] sat,
                                              input logic [7:0] bright, input logic last);
    logic [31:0] v, tmp, base, prod, slope;
    logic [7:0]  red, green, blue, white;
    logic [7:0]  chan[4];
    logic [2:0]  sextant;
    logic [1:0]  pair;
    logic        is_rgbw;
    int unsigned nchan, n;
    spi_word_t   w;
    is_rgbw = (order_q == hsvled_pkg::OrderRgbw);
    white   = 8'd0;
    v       = {24'd0, bright};
    if (sat == 8'd0) begin
      // grey: all channels equal, or all to white in rgbw
      if (is_rgbw) begin
        white = bright;
        v     = 32'd0;
      end
      red   = v[7:0];
      green = v[7:0];
      blue  = v[7:0];
    end else begin
      sextant = 3'(hue[15:8] % 8'd6);
      tmp  = v * (32'd255 - {24'd0, sat}) + 32'd1;
      tmp  = tmp + (tmp >> 8);
      base = (tmp >> 8) & 32'hff;
      if (!sextant[0]) begin
        prod = ({24'd0, sat} * (32'd256 - {24'd0, hue[7:0]})) & 32'hffff;
      end else begin
        prod = ({24'd0, sat} * {24'd0, hue[7:0]}) & 32'hffff;
      end
      slope = v * ((32'd255 << 8) - prod);
      slope = slope + (slope >> 8);
      slope = slope + v;
      slope = slope >> 16;
      if (is_rgbw) begin
        white = base[7:0];
        v     = (v - base) & 32'hff;
        slope = (slope - base) & 32'hff;
      end
      slope = slope & 32'hff;
      case (sextant)
        3'd0: begin
          red = v[7:0];     green = slope[7:0]; blue = base[7:0];
        end
        3'd1: begin
          red = slope[7:0]; green = v[7:0];     blue = base[7:0];
        end
        3'd2: begin
          red = base[7:0];  green = v[7:0];     blue = slope[7:0];
        end
        3'd3: begin
          red = base[7:0];  green = slope[7:0]; blue = v[7:0];
        end
        3'd4: begin
          red = slope[7:0]; green = base[7:0];  blue = v[7:0];
        end
        default: begin
          red = v[7:0];     green = base[7:0];  blue = slope[7:0];
        end
      endcase
    end
    if (order_q == hsvled_pkg::OrderGrb) begin
      chan[0] = green;
      chan[1] = red;
    end else begin
      chan[0] = red;
      chan[1] = green;
    end
    chan[2] = blue;
    chan[3] = white;
    nchan = is_rgbw ? 4 : 3;
    n = 0;
    for (int c = 0; c < nchan; c++) begin
      for (int k = 0; k < 4; k++) begin
        pair        = 2'(chan[c] >> (6 - 2 * k));
        w.spi_byte  = code_q[pair];
        w.pixel_end = (n == nchan * 4 - 1);
        w.frame_end = w.pixel_end && last;
        expected_bytes.push_back(w);
        n++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q   = hsvled_pkg::OrderGrb;
      code_q[0] = hsvled_pkg::CodePair00Rst;
      code_q[1] = hsvled_pkg::CodePair01Rst;
      code_q[2] = hsvled_pkg::CodePair10Rst;
      code_q[3] = hsvled_pkg::CodePair11Rst;
      expected_bytes.delete();
    end else begin
      if (pop_i && !empty_i) begin
        got_word = '{spi_byte: spi_byte_i, pixel_end: pixel_end_i, frame_end: frame_end_i};
        if (expected_bytes.size() == 0) begin
          byte_faults++;
          if (byte_faults <= 10) begin
            $display("%0t: unexpected word spi_byte=%h pixel_end=%b frame_end=%b",
                     $time, spi_byte_i, pixel_end_i, frame_end_i);
          end
        end else begin
          want_word = expected_bytes.pop_front();
          if (got_word !== want_word) begin
            byte_faults++;
            if (byte_faults <= 10) begin
              $display("%0t: word mismatch spi_byte exp %h got %h, pixel_end exp %b got %b, %s",
                       $time, want_word.spi_byte, got_word.spi_byte, want_word.pixel_end,
                       got_word.pixel_end, $sformatf("frame_end exp %b got %b",
                       want_word.frame_end, got_word.frame_end));
            end
          end
        end
      end
      if (push_i && !full_i) begin
        predict_pixel_bytes(hue_i, saturation_i, brightness_i, last_pixel_i);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          hsvled_pkg::RegPixelOrder: order_q   = cfg_data_i[1:0];
          hsvled_pkg::RegCodePair00: code_q[0] = cfg_data_i;
          hsvled_pkg::RegCodePair01: code_q[1] = cfg_data_i;
          hsvled_pkg::RegCodePair10: code_q[2] = cfg_data_i;
          hsvled_pkg::RegCodePair11: code_q[3] = cfg_data_i;
          default: ;
        endcase
      end
    end
    fail_count_o <= byte_faults;
    pending_o    <= expected_bytes.size();
  end

endmodule

[verif/hsv_pixel_to_led_bitstream_tb.sv]
`timescale 1ns / 100ps

module hsv_pixel_to_led_bitstream_tb;

  // the package names only the three real orders; code 3 must behave like rgb
  localparam logic [1:0] OrderSpare = 2'd3;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [15:0] hue_i        = '0;
  logic [7:0]  saturation_i = '0;
  logic [7:0]  brightness_i = '0;
  logic        last_pixel_i = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [7:0]  spi_byte_o;
  logic        pixel_end_o;
  logic        frame_end_o;
  logic        cfg_we_i     = 1'b0;
  logic [2:0]  cfg_index_i  = '0;
  logic [7:0]  cfg_data_i   = '0;

  int unsigned fail_count;
  int unsigned pending_bytes;

  // traffic shaping knobs shared by the sender and the receiver
  bit quiet     = 1'b0;   // no random idling on either side
  bit hold_long = 1'b0;   // receiver holds pop low for a long stretch, then clears it

  hsv_pixel_to_led_bitstream uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .last_pixel_i (last_pixel_i),
    .empty        (empty),
    .pop          (pop),
    .spi_byte_o   (spi_byte_o),
    .pixel_end_o  (pixel_end_o),
    .frame_end_o  (frame_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // predicts every spi word from the accepted pixels and compares what is popped
  hsv_led_spi_checker spi_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .last_pixel_i (last_pixel_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .spi_byte_i   (spi_byte_o),
    .pixel_end_i  (pixel_end_o),
    .frame_end_i  (frame_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_bytes)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // offer one pixel word, maybe after a random idle burst, and return on the
  // edge that takes it; full is looked at on the falling edge where it is stable
  task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
                            input logic [7:0] bright, input logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    push         <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= bright;
    last_pixel_i <= last;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // stop offering and wait until every predicted spi word has been popped,
  // then let the block sit idle before any register write
  task automatic drain;
    push <= 1'b0;
    @(negedge clk_i);
    while (pending_bytes != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // all five registers, one per cycle, only while the block is idle
  task automatic program_regs(input logic [1:0] order, input logic [7:0] c00,
                              input logic [7:0] c01, input logic [7:0] c10,
                              input logic [7:0] c11);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= hsvled_pkg::RegPixelOrder;
    cfg_data_i  <= {6'd0, order};
    @(posedge clk_i);
    cfg_index_i <= hsvled_pkg::RegCodePair00;
    cfg_data_i  <= c00;
    @(posedge clk_i);
    cfg_index_i <= hsvled_pkg::RegCodePair01;
    cfg_data_i  <= c01;
    @(posedge clk_i);
    cfg_index_i <= hsvled_pkg::RegCodePair10;
    cfg_data_i  <= c10;
    @(posedge clk_i);
    cfg_index_i <= hsvled_pkg::RegCodePair11;
    cfg_data_i  <= c11;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // corner pixels: grey at black/full/mid, every sextant, positions 0 and 255,
  // sextant bytes past 5 that wrap modulo six, saturation 1 and 255, value 0
  task automatic send_corner_pixels;
    send_pixel(16'h0000, 8'd0,   8'd0,   1'b0);
    send_pixel(16'h1234, 8'd0,   8'd255, 1'b0);
    send_pixel(16'hffff, 8'd0,   8'h5a,  1'b1);
    send_pixel(16'h0000, 8'd255, 8'd255, 1'b0);
    send_pixel(16'h01ff, 8'd255, 8'd255, 1'b0);
    send_pixel(16'h0280, 8'd128, 8'd200, 1'b0);
    send_pixel(16'h0340, 8'd1,   8'd255, 1'b0);
    send_pixel(16'h04c0, 8'd200, 8'd1,   1'b0);
    send_pixel(16'h05ff, 8'd255, 8'd128, 1'b0);
    send_pixel(16'h0680, 8'd100, 8'd100, 1'b0);
    send_pixel(16'hff01, 8'd255, 8'd255, 1'b1);
    send_pixel(16'h0b7f, 8'd254, 8'd0,   1'b1);
  endtask

  // saturation and value lean toward their extremes, hue is fully random
  function automatic logic [7:0] pick_level;
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // receiver: pop bursts, a long hold when asked, steady pop otherwise
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // sender and verdict
  initial begin
    logic [1:0] order;
    logic [7:0] codes[4];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first: grb order with the default code words
    send_corner_pixels();
    drain();

    // same corners with white extraction and extreme code words
    program_regs(hsvled_pkg::OrderRgbw, 8'h00, 8'hff, 8'h0f, 8'hf0);
    send_corner_pixels();
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       order = hsvled_pkg::OrderGrb;
        1:       order = hsvled_pkg::OrderRgb;
        2:       order = hsvled_pkg::OrderRgbw;
        default: order = OrderSpare;
      endcase
      for (int i = 0; i < 4; i++) codes[i] = 8'($urandom_range(0, 255));
      if (phase == 0) begin
        codes = '{8'h00, 8'hff, 8'h00, 8'hff};
      end else if (phase == 7) begin
        codes = '{8'hff, 8'h00, 8'hff, 8'h00};
      end
      program_regs(order, codes[0], codes[1], codes[2], codes[3]);
      // long receiver hold fills the block while pixels keep coming
      hold_long = (phase == 1);
      // idle-free stretches, the closing one included
      quiet     = (phase == 4 || phase == 7);
      for (int n = 0; n < 56; n++) begin
        send_pixel(16'($urandom_range(0, 65535)), pick_level(), pick_level(),
                   1'($urandom_range(0, 3) == 0));
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("hsv_pixel_to_led_bitstream_tb: done, clean");
    end else begin
      $display("hsv_pixel_to_led_bitstream_tb: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("hsv_pixel_to_led_bitstream_tb: done, errors");
    $finish;
  end

endmodule

[files.f]
design/hsvled_pkg.sv
design/hsvled_front.sv
design/hsvled_queue.sv
design/hsvled_back.sv
design/hsv_pixel_to_led_bitstream.sv
verif/hsv_led_spi_checker.sv
verif/hsv_pixel_to_led_bitstream_tb.sv
